// ----- rtl/core/pift_pkg.sv -----
// Shared types and constants for the point-in-frustum test core.
package pift_pkg;

    // Number of bounding planes held in the plane table
    localparam int NUM_PLANES = 6;

    // Field widths of the request and result items
    localparam int PLANE_IDX_W = 3;
    localparam int NORMAL_W    = 16;
    localparam int COORD_W     = 32;
    localparam int S_TDATA_W   = 152;
    localparam int M_TDATA_W   = 8;

    // Exact dot product widths: difference, product, three-term sum
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = NORMAL_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 2;

    // Result queue: covers every query in flight plus one waiting result
    localparam int RESULT_DEPTH = 4;
    localparam int RES_PTR_W    = $clog2(RESULT_DEPTH);
    localparam int RES_CNT_W    = $clog2(RESULT_DEPTH + 1);

    // Request kinds carried in s_tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    localparam int REG_FRUSTUM_ENABLED = 0;

    // One plane: unit normal (Q1.15) and a point on the plane (Q16.16)
    typedef struct packed {
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_arr_t;

    // Query point held in the input register
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } query_t;

    // Result written into the result queue
    typedef struct packed {
        logic valid;
        logic in_frustum;
    } result_t;

endpackage

// ----- rtl/core/pift_plane_table.sv -----
// Plane table: one register entry per bounding plane, written by load requests.
module pift_plane_table (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [pift_pkg::PLANE_IDX_W-1:0]        wr_idx,
    input  pift_pkg::plane_t                        wr_entry,
    output pift_pkg::plane_arr_t                    planes
);

    pift_pkg::plane_arr_t table_reg;

    // Entry write; an index beyond the table matches no entry and is dropped
    always_ff @(posedge aclk) begin
        for (int k = 0; k < pift_pkg::NUM_PLANES; k++) begin
            if (wr_en && (32'(wr_idx) == k)) begin
                table_reg[k] <= wr_entry;
            end
        end
    end

    assign planes = table_reg;

endmodule

// ----- rtl/core/pift_plane_eval.sv -----
// Plane test: exact products per plane and axis, then sign of each sum.
module pift_plane_eval (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pift_pkg::query_t       query,
    input  pift_pkg::plane_arr_t   planes,
    input  logic                   frustum_enabled,
    output pift_pkg::result_t      result
);

    logic signed [pift_pkg::PROD_W-1:0] prod_reg  [pift_pkg::NUM_PLANES][3];
    logic signed [pift_pkg::PROD_W-1:0] prod_next [pift_pkg::NUM_PLANES][3];
    logic                               valid_reg;
    logic                               valid_next;

    // Stage one: difference to the plane point times the normal component
    always_comb begin
        logic signed [pift_pkg::DIFF_W-1:0] dx;
        logic signed [pift_pkg::DIFF_W-1:0] dy;
        logic signed [pift_pkg::DIFF_W-1:0] dz;
        for (int k = 0; k < pift_pkg::NUM_PLANES; k++) begin
            dx = {query.x[pift_pkg::COORD_W-1], query.x}
               - {planes[k].px[pift_pkg::COORD_W-1], planes[k].px};
            dy = {query.y[pift_pkg::COORD_W-1], query.y}
               - {planes[k].py[pift_pkg::COORD_W-1], planes[k].py};
            dz = {query.z[pift_pkg::COORD_W-1], query.z}
               - {planes[k].pz[pift_pkg::COORD_W-1], planes[k].pz};
            prod_next[k][0] = planes[k].nx * dx;
            prod_next[k][1] = planes[k].ny * dy;
            prod_next[k][2] = planes[k].nz * dz;
        end
    end

    assign valid_next = query.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Products are payload and carry no reset
    always_ff @(posedge aclk) begin
        for (int k = 0; k < pift_pkg::NUM_PLANES; k++) begin
            for (int a = 0; a < 3; a++) begin
                prod_reg[k][a] <= prod_next[k][a];
            end
        end
    end

    // Stage two: a strictly positive sum puts the point beyond that plane
    always_comb begin
        logic signed [pift_pkg::SUM_W-1:0] sum;
        logic                              any_beyond;
        any_beyond = 1'b0;
        for (int k = 0; k < pift_pkg::NUM_PLANES; k++) begin
            sum = {{2{prod_reg[k][0][pift_pkg::PROD_W-1]}}, prod_reg[k][0]}
                + {{2{prod_reg[k][1][pift_pkg::PROD_W-1]}}, prod_reg[k][1]}
                + {{2{prod_reg[k][2][pift_pkg::PROD_W-1]}}, prod_reg[k][2]};
            if (!sum[pift_pkg::SUM_W-1] && (|sum)) begin
                any_beyond = 1'b1;
            end
        end
        result.valid      = valid_reg;
        result.in_frustum = frustum_enabled && !any_beyond;
    end

endmodule

// ----- rtl/core/pift_result_fifo.sv -----
// Result queue: holds answers until the receiver takes them.
module pift_result_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pift_pkg::result_t                   wr,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_inside
);

    localparam int RESULT_BITS = pift_pkg::RESULT_DEPTH;

    logic [RESULT_BITS-1:0]                     data_reg;
    logic [pift_pkg::RES_PTR_W-1:0]             wr_ptr_reg;
    logic [pift_pkg::RES_PTR_W-1:0]             rd_ptr_reg;
    logic [pift_pkg::RES_CNT_W-1:0]             count_reg;
    logic [pift_pkg::RES_CNT_W-1:0]             count_next;
    logic                                       rd_en;

    assign m_tvalid = (count_reg != '0);
    assign m_inside = data_reg[rd_ptr_reg];
    assign rd_en    = m_tvalid && m_tready;

    // Occupancy follows writes and reads
    always_comb begin
        count_next = count_reg;
        if (wr.valid && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (!wr.valid && rd_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            data_reg[wr_ptr_reg] <= wr.in_frustum;
        end
    end

    // Occupancy never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pift_pkg::RES_CNT_W'(pift_pkg::RESULT_DEPTH))
        else $error("result queue occupancy beyond depth");

    // The input credit must keep a write off a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == pift_pkg::RES_CNT_W'(pift_pkg::RESULT_DEPTH)) && wr.valid |-> rd_en)
        else $error("result written into a full queue");

    // Pointers stay apart by the occupancy
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == pift_pkg::RES_PTR_W'(count_reg))
        else $error("result queue pointers disagree with occupancy");

endmodule

// ----- rtl/core/point_in_frustum_test_core.sv -----
// Top level of the point-in-frustum test core.
//
// Requests arrive on the s_ stream. s_tuser selects the kind: a load writes
// plane_index's entry (normal and plane point) and gives no result; a query
// carries a point and gives one result on the m_ stream, m_tdata[0] = 1 when
// the point is on or inside all planes. The frustum_enabled register (APB,
// address 0) must be set for any query to answer inside.
// A query's point passes the input register, the product register, then the
// result queue. Throughput is one request per cycle while s_tready is high;
// the plane products of all planes and axes are computed in parallel, one
// multiplier each.
// A load takes effect for every query accepted after it.
// Reset clears the enable register, the pipeline valids and the result queue;
// the plane table keeps no reset and must be loaded before a query is made
// with the frustum enabled.
// When the receiver stalls, results collect in a four-entry queue; s_tready
// drops once four queries are pending, so nothing is lost.
module point_in_frustum_test_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: plane_index[3], normal_x[16], normal_y[16],
    // normal_z[16], coord_x[32], coord_y[32], coord_z[32], zero fill[5]
    input  logic [pift_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: action[1] (0 load, 1 query)
    input  logic                              s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: inside_res[1], zero fill[7]
    output logic [pift_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic                                  enabled_reg;
    logic                                  cfg_wr;
    logic                                  s_accept;
    logic                                  load_wr;
    logic                                  query_acc;
    logic                                  m_accept;
    logic [pift_pkg::PLANE_IDX_W-1:0]      in_idx;
    pift_pkg::plane_t                      in_entry;
    pift_pkg::plane_arr_t                  planes;
    pift_pkg::query_t                      query_reg;
    pift_pkg::query_t                      query_next;
    pift_pkg::result_t                     result;
    logic [pift_pkg::RES_CNT_W-1:0]        pend_reg;
    logic [pift_pkg::RES_CNT_W-1:0]        pend_next;
    logic                                  m_inside;

    // Configuration register; decoded from paddr[2] alone, so addresses 0 to 3 reach it
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (32'(paddr[2]) == pift_pkg::REG_FRUSTUM_ENABLED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_wr) begin
            enabled_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(paddr[2]) == pift_pkg::REG_FRUSTUM_ENABLED) begin
            prdata[0] = enabled_reg;
        end
    end

    // Request unpacking
    assign in_idx      = s_tdata[2:0];
    assign in_entry.nx = s_tdata[18:3];
    assign in_entry.ny = s_tdata[34:19];
    assign in_entry.nz = s_tdata[50:35];
    assign in_entry.px = s_tdata[82:51];
    assign in_entry.py = s_tdata[114:83];
    assign in_entry.pz = s_tdata[146:115];

    // Credit: queries accepted but not yet delivered stay within the queue depth
    assign s_tready  = (pend_reg < pift_pkg::RES_CNT_W'(pift_pkg::RESULT_DEPTH));
    assign s_accept  = s_tvalid && s_tready;
    assign load_wr   = s_accept && (s_tuser == pift_pkg::ACT_LOAD);
    assign query_acc = s_accept && (s_tuser == pift_pkg::ACT_QUERY);
    assign m_accept  = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (query_acc && !m_accept) begin
            pend_next = pend_reg + 1'b1;
        end else if (!query_acc && m_accept) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Input register for query points
    always_comb begin
        query_next.valid = query_acc;
        query_next.x     = in_entry.px;
        query_next.y     = in_entry.py;
        query_next.z     = in_entry.pz;
    end

    // Only the valid bit is reset; the point is payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg.valid <= 1'b0;
        end else begin
            query_reg.valid <= query_next.valid;
        end
        query_reg.x <= query_next.x;
        query_reg.y <= query_next.y;
        query_reg.z <= query_next.z;
    end

    pift_plane_table u_table (
        .aclk     (aclk),
        .wr_en    (load_wr),
        .wr_idx   (in_idx),
        .wr_entry (in_entry),
        .planes   (planes)
    );

    pift_plane_eval u_eval (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .query           (query_reg),
        .planes          (planes),
        .frustum_enabled (enabled_reg),
        .result          (result)
    );

    pift_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_inside (m_inside)
    );

    assign m_tdata = {{(pift_pkg::M_TDATA_W-1){1'b0}}, m_inside};

    // A result is only offered while some query is pending
    a_valid_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != '0))
        else $error("result offered with no query pending");

endmodule
